// File: rtl/masked_byte_pattern_scanner_defines.svh
// assertion macros shared by the scanner rtl
// depends on nothing; asserting modules must have i_clk and i_rst_n in scope
`ifndef MASKED_BYTE_PATTERN_SCANNER_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SCANNER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// checked property, idle while reset is asserted
`define MBPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked property, also while reset is asserted
`define MBPS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define MBPS_ASSERT(lbl, prop, msg)
`define MBPS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/mbps_pkg.sv
// shared types and constants for the masked byte pattern scanner
// no dependencies
package mbps_pkg;

    // default sizing
    localparam int DEF_MAX_PATTERN_BYTES = 32;
    localparam int DEF_BUFFER_BYTES      = 4096;

    // fixed field widths
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_IDX_W         = 3;
    localparam int OFFSET_W          = 12;
    localparam int LEN_REG_W         = 6;
    localparam int WILD_W            = 32;
    localparam int PATTERN_REG_BYTES = 32;
    localparam int PAT_IDX_W         = 5;
    localparam int PATTERN_WORDS     = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WILDCARD_MASK  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd5;

    // input transaction payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } t_in_item;

    // result transaction payload
    typedef struct packed {
        logic                match_found;
        logic [OFFSET_W-1:0] match_offset;
        logic                buffer_done;
    } t_out_item;

endpackage

// File: rtl/mbps_cfg.sv
// configuration registers and the pattern aligned to the window
// depends on mbps_pkg
module mbps_cfg #(
    parameter int MAX_PATTERN_BYTES = mbps_pkg::DEF_MAX_PATTERN_BYTES
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_wr_en,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]       i_wr_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]      i_wr_data,
    output logic [MAX_PATTERN_BYTES-1:0][7:0]    o_align_pat,
    output logic [MAX_PATTERN_BYTES-1:0]         o_align_care,
    output logic [$clog2(MAX_PATTERN_BYTES+1)-1:0] o_len_eff
);
    import mbps_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int EL_W  = (LEN_W > LEN_REG_W) ? LEN_W : LEN_REG_W;

    logic [PATTERN_WORDS-1:0][CFG_DATA_W-1:0] r_pat_word;
    logic [WILD_W-1:0]                        r_wild;
    logic [LEN_REG_W-1:0]                     r_len;

    logic [PATTERN_REG_BYTES-1:0][7:0]        pat_bytes;
    logic [EL_W-1:0]                          len_ext;
    logic [LEN_W-1:0]                         n_len_eff;
    logic [MAX_PATTERN_BYTES-1:0][7:0]        n_align_pat;
    logic [MAX_PATTERN_BYTES-1:0]             n_align_care;

    logic [MAX_PATTERN_BYTES-1:0][7:0]        r_align_pat;
    logic [MAX_PATTERN_BYTES-1:0]             r_align_care;
    logic [LEN_W-1:0]                         r_len_eff;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_word <= '0;
            r_wild     <= '0;
            r_len      <= LEN_REG_W'(1);
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                REG_PATTERN_WORD_0: r_pat_word[0] <= i_wr_data;
                REG_PATTERN_WORD_1: r_pat_word[1] <= i_wr_data;
                REG_PATTERN_WORD_2: r_pat_word[2] <= i_wr_data;
                REG_PATTERN_WORD_3: r_pat_word[3] <= i_wr_data;
                REG_WILDCARD_MASK:  r_wild        <= i_wr_data[WILD_W-1:0];
                REG_PATTERN_LENGTH: r_len         <= i_wr_data[LEN_REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // byte k of the pattern, byte 0 lowest in word 0
    assign pat_bytes = r_pat_word;

    // clamp the length to 1..MAX_PATTERN_BYTES
    always_comb begin
        len_ext = EL_W'(r_len);
        if (len_ext == '0) begin
            len_ext = EL_W'(1);
        end else if (len_ext > EL_W'(MAX_PATTERN_BYTES)) begin
            len_ext = EL_W'(MAX_PATTERN_BYTES);
        end
        n_len_eff = LEN_W'(len_ext);
    end

    // slot a of the window (a bytes ago) faces pattern byte len-1-a
    always_comb begin
        logic [EL_W-1:0] k;
        logic            in_reg;
        for (int a = 0; a < MAX_PATTERN_BYTES; a++) begin
            k      = len_ext - EL_W'(1) - EL_W'(a);
            in_reg = (k < EL_W'(PATTERN_REG_BYTES));
            n_align_pat[a]  = in_reg ? pat_bytes[k[PAT_IDX_W-1:0]] : 8'h00;
            n_align_care[a] = (EL_W'(a) < len_ext)
                              && !(in_reg && r_wild[k[PAT_IDX_W-1:0]]);
        end
    end

    // aligned copy, registered from the configuration registers
    always_ff @(posedge i_clk) begin
        r_align_pat  <= n_align_pat;
        r_align_care <= n_align_care;
        r_len_eff    <= n_len_eff;
    end

    assign o_align_pat  = r_align_pat;
    assign o_align_care = r_align_care;
    assign o_len_eff    = r_len_eff;

endmodule

// File: rtl/mbps_scan.sv
// input register, byte window, buffer position and window compare
// depends on mbps_pkg and masked_byte_pattern_scanner_defines.svh
`include "masked_byte_pattern_scanner_defines.svh"
module mbps_scan #(
    parameter int MAX_PATTERN_BYTES = mbps_pkg::DEF_MAX_PATTERN_BYTES,
    parameter int BUFFER_BYTES      = mbps_pkg::DEF_BUFFER_BYTES
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  mbps_pkg::t_in_item                     i_in_item,
    input  logic                                   i_take,
    output logic                                   o_res_valid,
    output mbps_pkg::t_out_item                    o_res_item,
    input  logic [MAX_PATTERN_BYTES-1:0][7:0]      i_align_pat,
    input  logic [MAX_PATTERN_BYTES-1:0]           i_align_care,
    input  logic [$clog2(MAX_PATTERN_BYTES+1)-1:0] i_len_eff
);
    import mbps_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int WIN_D = MAX_PATTERN_BYTES - 1;
    localparam int PW    = $clog2(BUFFER_BYTES);
    localparam int CW    = ((PW > LEN_W) ? PW : LEN_W) + 1;

    logic                                r_s1_valid;
    t_in_item                            r_s1_item;
    logic [WIN_D-1:0][7:0]               r_win;
    logic [PW-1:0]                       r_pos;

    logic                                s1_fire;
    logic [MAX_PATTERN_BYTES-1:0][7:0]   cand;
    logic [MAX_PATTERN_BYTES-1:0]        hit;
    logic [CW-1:0]                       pos1;
    logic                                pos_ok;
    logic                                match;
    logic [CW-1:0]                       off;
    logic [WIN_D-1:0][7:0]               n_win;
    logic [PW-1:0]                       n_pos;

    // stage advances when the result register can take it
    assign s1_fire    = r_s1_valid && i_take;
    assign o_in_ready = !r_s1_valid || s1_fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_item <= i_in_item;
        end
    end

    // window compare, all slots in parallel
    always_comb begin
        cand[0] = r_s1_item.data_byte;
        for (int a = 1; a < MAX_PATTERN_BYTES; a++) begin
            cand[a] = r_win[a-1];
        end
        for (int a = 0; a < MAX_PATTERN_BYTES; a++) begin
            hit[a] = !i_align_care[a] || (i_align_pat[a] == cand[a]);
        end
    end

    // enough bytes of this buffer seen, and start offset
    assign pos1   = CW'(r_pos) + CW'(1);
    assign pos_ok = (pos1 >= CW'(i_len_eff));
    assign off    = pos1 - CW'(i_len_eff);
    assign match  = pos_ok && (&hit);

    always_comb begin
        o_res_valid             = s1_fire && (match || r_s1_item.end_of_buffer);
        o_res_item.match_found  = match;
        o_res_item.match_offset = match ? OFFSET_W'(off) : '0;
        o_res_item.buffer_done  = r_s1_item.end_of_buffer;
    end

    // window shift and position, restart on the last byte
    always_comb begin
        if (r_s1_item.end_of_buffer) begin
            n_win = '0;
            n_pos = '0;
        end else begin
            n_win[0] = r_s1_item.data_byte;
            for (int a = 1; a < WIN_D; a++) begin
                n_win[a] = r_win[a-1];
            end
            n_pos = (r_pos == PW'(BUFFER_BYTES - 1)) ? '0 : r_pos + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
            r_pos <= '0;
        end else if (s1_fire) begin
            r_win <= n_win;
            r_pos <= n_pos;
        end
    end

    `MBPS_ASSERT(a_restart_after_last, (s1_fire && r_s1_item.end_of_buffer) |=> (r_pos == '0), "position not restarted after last byte")
    `MBPS_ASSERT(a_pos_in_range, r_pos <= PW'(BUFFER_BYTES - 1), "buffer position out of range")
    `MBPS_ASSERT(a_s1_held, (r_s1_valid && !s1_fire) |=> (r_s1_valid && $stable(r_s1_item)), "stalled byte lost or changed")

endmodule

// File: rtl/masked_byte_pattern_scanner.sv
// Masked byte pattern scanner, top level. Takes one byte per cycle while no result waits
// untaken. A byte is compared, all window slots in parallel, while it sits in the input
// register, and its result is loaded into the result register, which drives o_out_valid,
// once that register is empty or being taken. The compare of every window slot against
// the aligned pattern sets the cycle. While a result waits untaken, the byte in the input
// register holds and o_in_ready drops. Bytes that neither end a match nor end a buffer
// produce no result. The configuration port is always ready; a write reaches the compare
// via the config registers and the aligned copy. There is no clearing pass after reset.
// depends on mbps_pkg, mbps_cfg, mbps_scan and masked_byte_pattern_scanner_defines.svh
`include "masked_byte_pattern_scanner_defines.svh"
module masked_byte_pattern_scanner #(
    parameter int MAX_PATTERN_BYTES = mbps_pkg::DEF_MAX_PATTERN_BYTES,
    parameter int BUFFER_BYTES      = mbps_pkg::DEF_BUFFER_BYTES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  mbps_pkg::t_in_item              i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output mbps_pkg::t_out_item             o_out_item,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mbps_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);

    logic [MAX_PATTERN_BYTES-1:0][7:0] align_pat;
    logic [MAX_PATTERN_BYTES-1:0]      align_care;
    logic [LEN_W-1:0]                  len_eff;
    logic                              take;
    logic                              res_valid;
    t_out_item                         res_item;
    logic                              r_out_valid;
    t_out_item                         r_out_item;

    // configuration transactions are taken every cycle
    assign o_cfg_ready = 1'b1;

    mbps_cfg #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (i_cfg_valid),
        .i_wr_index   (i_cfg_index),
        .i_wr_data    (i_cfg_data),
        .o_align_pat  (align_pat),
        .o_align_care (align_care),
        .o_len_eff    (len_eff)
    );

    mbps_scan #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
        .BUFFER_BYTES      (BUFFER_BYTES)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_take       (take),
        .o_res_valid  (res_valid),
        .o_res_item   (res_item),
        .i_align_pat  (align_pat),
        .i_align_care (align_care),
        .i_len_eff    (len_eff)
    );

    // result register, free when empty or being taken this cycle
    assign take = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_item <= res_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `MBPS_ASSERT(a_result_has_cause,
        r_out_valid |-> (r_out_item.match_found || r_out_item.buffer_done),
        "result with neither match nor buffer end")
    `MBPS_ASSERT(a_offset_zero_no_match,
        (r_out_valid && !r_out_item.match_found) |-> (r_out_item.match_offset == '0),
        "offset set without a match")
    `MBPS_ASSERT_ALWAYS(a_no_overwrite,
        res_valid |-> (!r_out_valid || i_out_ready),
        "pending result overwritten")

endmodule
